// ----- sv/smnw_pkg.sv -----
// Shared constants, types and result codes of the sorted merge engine.
package smnw_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KEY_W = 64;
  localparam int OFF_W = 64;
  localparam int LEN_W = 32;
  localparam int STM_W = 64;
  localparam int SRC_W = 4;

  typedef enum logic [1:0] {
    ST_LOADED   = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_TUPLE    = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PULL = 1'b1
  } action_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [STM_W-1:0] stamp;
    logic [SRC_W-1:0] source;
  } tuple_t;

  typedef struct packed {
    status_t status;
    tuple_t  tup;
    logic    last;
  } result_t;

  // Control from the sequencer to the candidate picker.
  typedef struct packed {
    logic             clear;
    logic             beat_valid;
    logic             emitted_any;
    logic [KEY_W-1:0] last_key;
  } pick_ctrl_t;

  // Status from the candidate picker.
  typedef struct packed {
    logic found;
    logic more;
  } pick_stat_t;

endpackage

// ----- sv/smnw_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
interface smnw_in_if import smnw_pkg::*;;
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [OFF_W-1:0] value_offset;
  logic [LEN_W-1:0] value_length;
  logic [STM_W-1:0] stamp;
  logic [SRC_W-1:0] source_index;

  modport source (
    output valid, action, key, value_offset, value_length, stamp, source_index,
    input  ready
  );
  modport sink (
    input  valid, action, key, value_offset, value_length, stamp, source_index,
    output ready
  );
endinterface

interface smnw_out_if import smnw_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] out_key;
  logic [OFF_W-1:0] out_offset;
  logic [LEN_W-1:0] out_length;
  logic [STM_W-1:0] out_stamp;
  logic [SRC_W-1:0] out_source;
  logic             last;

  modport source (
    output valid, status, out_key, out_offset, out_length, out_stamp, out_source, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_offset, out_length, out_stamp, out_source, last,
    output ready
  );
endinterface

// ----- sv/smnw_pick.sv -----
// Running best-candidate register and compare unit for one merge scan.
module smnw_pick import smnw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pick_ctrl_t ctrl,
  input  tuple_t     rd_tup,
  output tuple_t     best,
  output pick_stat_t stat
);

  tuple_t           best_r;
  logic             found_r;
  logic [KEY_W-1:0] max_key_r;
  logic             eligible;
  logic             better;
  logic             take;

  always_comb begin
    eligible = !ctrl.emitted_any || (rd_tup.key > ctrl.last_key);
    // smaller key first; same key: newer stamp, then lower source
    better = !found_r || (rd_tup.key < best_r.key) ||
             ((rd_tup.key == best_r.key) &&
              ((rd_tup.stamp > best_r.stamp) ||
               ((rd_tup.stamp == best_r.stamp) && (rd_tup.source < best_r.source))));
    take = ctrl.beat_valid && eligible && better;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r <= rd_tup;
    end
    if (ctrl.clear) begin
      max_key_r <= '0;
    end else if (ctrl.beat_valid && (rd_tup.key > max_key_r)) begin
      max_key_r <= rd_tup.key;
    end
  end

  assign best       = best_r;
  assign stat.found = found_r;
  assign stat.more  = max_key_r > best_r.key;

endmodule

// ----- sv/sorted_merge_newest_wins.sv -----
// Top level of the sorted merge engine: tuple store, scan sequencer and result register.
//
//  channel  dir  beat                                        accepted when
//  in_s     in   action, key, offset, length, stamp, source  valid & ready
//  out_s    out  status, tuple fields, last                  valid & ready
//
// A load writes the tuple at the fill count and sends the answer to the
// result register. A pull scans every stored entry through the single read
// port of the tuple memory, one entry a cycle; each read is registered before
// the compare, and the answer is registered once the last read beat has settled
// and the result register is free. On an empty store the scan is skipped.
// Reset clears the fill count, the scan and drain state and the result valid flag;
// the memory holds what it held, as entries at or above the fill count are never read.
// A stall on out_s holds the result register; a pull may still start and
// its answer waits at the end of the scan until the register is free.
module sorted_merge_newest_wins import smnw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  smnw_in_if.sink         in_s,
  smnw_out_if.source      out_s
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRAP
  } state_t;

  // Tuple store: one write port for loads, one read port for the scan.
  // Loads only land in idle and read beats are only taken from scan cycles, so a
  // read beat and a write never meet on the same entry.
  tuple_t           mem [CAPACITY];

  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [IDX_W-1:0] addr_r,      addr_nxt;
  logic             rd_v_r;
  tuple_t           rd_q_r;
  logic             emitted_r,   emitted_nxt;
  logic [KEY_W-1:0] last_key_r,  last_key_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r,       out_nxt;

  logic             in_fire;
  logic             out_free;
  logic             full;
  logic             wr_en;
  tuple_t           wr_tup;
  logic             scan_end;
  pick_ctrl_t       pick_ctrl;
  pick_stat_t       pick_stat;
  tuple_t           best;

  assign out_free = !out_valid_r || out_s.ready;
  assign full     = count_r == CNT_W'(CAPACITY);
  // A load needs the result register at once; a pull only at its end.
  assign in_s.ready = (state_r == S_IDLE) && (out_free || (in_s.action == ACT_PULL));
  assign in_fire  = in_s.valid && in_s.ready;
  assign scan_end = (CNT_W'(addr_r) + CNT_W'(1)) == count_r;

  assign wr_tup.key    = in_s.key;
  assign wr_tup.offset = in_s.value_offset;
  assign wr_tup.length = in_s.value_length;
  assign wr_tup.stamp  = in_s.stamp;
  assign wr_tup.source = in_s.source_index;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    emitted_nxt   = emitted_r;
    last_key_nxt  = last_key_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;

    pick_ctrl.clear       = 1'b0;
    pick_ctrl.beat_valid  = rd_v_r;
    pick_ctrl.emitted_any = emitted_r;
    pick_ctrl.last_key    = last_key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_s.action == ACT_LOAD) begin
            // store the tuple, or drop it when the store is full
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            if (full) begin
              out_nxt.status = ST_DROPPED;
            end else begin
              out_nxt.status = ST_LOADED;
              wr_en          = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else begin
            pick_ctrl.clear = 1'b1;
            addr_nxt        = '0;
            state_nxt       = (count_r == '0) ? S_WRAP : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (scan_end) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        // wait for the last read beat to settle and the result register to free
        if (!rd_v_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
          if (pick_stat.found) begin
            out_nxt.status = ST_TUPLE;
            out_nxt.tup    = best;
            out_nxt.last   = !pick_stat.more;
            emitted_nxt    = 1'b1;
            last_key_nxt   = best.key;
          end else begin
            // batch finished: empty the store and end the drain
            out_nxt.status = ST_FINISHED;
            count_nxt      = '0;
            emitted_nxt    = 1'b0;
            last_key_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_v_r      <= 1'b0;
      emitted_r   <= 1'b0;
      last_key_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_v_r      <= state_r == S_SCAN;
      emitted_r   <= emitted_nxt;
      last_key_r  <= last_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_tup;
    end
    rd_q_r <= mem[addr_r];
  end

  smnw_pick u_pick (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (pick_ctrl),
    .rd_tup (rd_q_r),
    .best   (best),
    .stat   (pick_stat)
  );

  assign out_s.valid      = out_valid_r;
  assign out_s.status     = out_r.status;
  assign out_s.out_key    = out_r.tup.key;
  assign out_s.out_offset = out_r.tup.offset;
  assign out_s.out_length = out_r.tup.length;
  assign out_s.out_stamp  = out_r.tup.stamp;
  assign out_s.out_source = out_r.tup.source;
  assign out_s.last       = out_r.last;

  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // no beat is taken while a scan is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_s.ready)
    else $error("input taken during scan");

  // read beats only follow scan cycles
  a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == S_SCAN))
    else $error("stray read beat");

  // a finished batch leaves the store empty
  a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP && !rd_v_r && out_free && !pick_stat.found) |=>
      (count_r == '0 && !emitted_r && out_valid_r && out_r.status == ST_FINISHED))
    else $error("batch end did not empty the store");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the sorted merge engine: predicted merge order checked beat by beat.
`timescale 1ns / 1ps
module tb_top;
  import smnw_pkg::*;

  // The slowest legal pull scans a full store and then waits on an 81% idle
  // receiver; for about 1700 such beats this limit still leaves a margin of
  // several times the run's length.
  localparam int CYCLE_LIMIT   = 3_000_000;
  // One full scan plus slack: nothing may turn up after this.
  localparam int SETTLE_CYCLES = CAPACITY + 40;
  localparam int ITEMS_PER_MIX = 550;
  localparam int POOL_MAX      = 32;
  localparam int REPORT_MAX    = 40;

  // Merge predictor and result store. note() runs on every accepted input beat
  // and queues the answer the engine owes; check() pops it against each output beat.
  class merge_scoreboard;
    tuple_t           slot [CAPACITY];
    int               fill;
    logic [KEY_W-1:0] last_key;
    bit               returned_any;
    bit               batch_ended;
    result_t          owed_q [$];
    int               errors;
    int               n_loaded, n_dropped, n_tuples, n_finished;

    function new();
      fill         = 0;
      last_key     = '0;
      returned_any = 1'b0;
      batch_ended  = 1'b0;
      errors       = 0;
      n_loaded     = 0;
      n_dropped    = 0;
      n_tuples     = 0;
      n_finished   = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note(action_t act, tuple_t t);
      result_t r;
      int      best;
      bit      found;
      bit      more;
      r     = '0;
      best  = 0;
      found = 1'b0;
      more  = 1'b0;
      if (act == ACT_LOAD) begin
        if (fill >= CAPACITY) begin
          r.status = ST_DROPPED;
        end else begin
          slot[fill]  = t;
          fill++;
          r.status    = ST_LOADED;
          batch_ended = 1'b0;
        end
      end else begin
        // Smallest eligible key; on equal keys the newest stamp, then the lowest
        // source. Strict compares keep the earliest load on a full tie.
        for (int i = 0; i < fill; i++) begin
          if (returned_any && slot[i].key <= last_key) continue;
          if (!found || slot[i].key < slot[best].key ||
              (slot[i].key == slot[best].key &&
               (slot[i].stamp > slot[best].stamp ||
                (slot[i].stamp == slot[best].stamp &&
                 slot[i].source < slot[best].source)))) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          // Nothing left above the last key: close the batch and empty the store.
          fill         = 0;
          last_key     = '0;
          returned_any = 1'b0;
          batch_ended  = 1'b1;
          r.status     = ST_FINISHED;
        end else begin
          for (int i = 0; i < fill; i++)
            if (slot[i].key > slot[best].key) more = 1'b1;
          r.status     = ST_TUPLE;
          r.tup        = slot[best];
          r.last       = !more;
          last_key     = slot[best].key;
          returned_any = 1'b1;
          batch_ended  = 1'b0;
        end
      end
      owed_q.insert(owed_q.size(), r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat with nothing owed, status %0d", got.status));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status: got %0d, expected %0d", got.status, want.status));
      if (got.tup.key !== want.tup.key)
        report($sformatf("key: got %h, expected %h", got.tup.key, want.tup.key));
      if (got.tup.offset !== want.tup.offset)
        report($sformatf("offset: got %h, expected %h", got.tup.offset, want.tup.offset));
      if (got.tup.length !== want.tup.length)
        report($sformatf("length: got %h, expected %h", got.tup.length, want.tup.length));
      if (got.tup.stamp !== want.tup.stamp)
        report($sformatf("stamp: got %h, expected %h", got.tup.stamp, want.tup.stamp));
      if (got.tup.source !== want.tup.source)
        report($sformatf("source: got %0d, expected %0d", got.tup.source, want.tup.source));
      if (got.last !== want.last)
        report($sformatf("last: got %b, expected %b", got.last, want.last));
      case (want.status)
        ST_LOADED:   n_loaded++;
        ST_DROPPED:  n_dropped++;
        ST_TUPLE:    n_tuples++;
        ST_FINISHED: n_finished++;
        default: ;
      endcase
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smnw_in_if  in_s ();
  smnw_out_if out_s ();

  sorted_merge_newest_wins u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s)
  );

  merge_scoreboard  merge_sb;
  int               send_idle_pct;
  int               take_idle_pct;
  int               items_sent;
  int               cycle_count;
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_size;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               merge_sb.pending());
      $display("** sorted_merge_newest_wins: FAILED **");
      $finish;
    end
  end

  // Receiver: toggle ready at the falling edge, take beats at the rising edge.
  always @(negedge clk) begin
    out_s.ready = ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin : take_beat
    result_t got;
    if (rst_n && out_s.valid === 1'b1 && out_s.ready === 1'b1) begin
      got.status     = status_t'(out_s.status);
      got.tup.key    = out_s.out_key;
      got.tup.offset = out_s.out_offset;
      got.tup.length = out_s.out_length;
      got.tup.stamp  = out_s.out_stamp;
      got.tup.source = out_s.out_source;
      got.last       = out_s.last;
      merge_sb.check(got);
    end
  end

  function automatic tuple_t mk_tuple(logic [KEY_W-1:0] k, logic [OFF_W-1:0] o,
                                      logic [LEN_W-1:0] l, logic [STM_W-1:0] s,
                                      logic [SRC_W-1:0] src);
    tuple_t t;
    t.key    = k;
    t.offset = o;
    t.length = l;
    t.stamp  = s;
    t.source = src;
    return t;
  endfunction

  // Draw keys from a small pool so duplicates and ties are common; now and then
  // take a fully random key so every key bit moves.
  function automatic tuple_t any_tuple();
    tuple_t t;
    if ($urandom_range(9) == 0) t.key = {$urandom, $urandom};
    else                        t.key = key_pool[$urandom_range(pool_size - 1)];
    case ($urandom_range(4))
      0, 1:    t.stamp = STM_W'($urandom_range(3));
      2:       t.stamp = '1;
      default: t.stamp = {$urandom, $urandom};
    endcase
    t.offset = {$urandom, $urandom};
    t.length = $urandom;
    t.source = SRC_W'($urandom_range(15));
    return t;
  endfunction

  task automatic fill_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: key_pool[i] = KEY_W'($urandom_range(15));
        1: key_pool[i] = {$urandom, $urandom};
        2: begin
          case ($urandom_range(2))
            0:       key_pool[i] = '0;
            1:       key_pool[i] = '1;
            default: key_pool[i] = {1'b1, {(KEY_W-1){1'b0}}};
          endcase
        end
        default: key_pool[i] = {30'd0, 2'($urandom_range(3)), $urandom};
      endcase
    end
  endtask

  // Present one beat from a falling edge, hold it until accepted, return at the
  // next falling edge with valid still high.
  task automatic push_beat(action_t act, tuple_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_s.valid = 1'b0;
      @(negedge clk);
    end
    in_s.valid        = 1'b1;
    in_s.action       = act;
    in_s.key          = t.key;
    in_s.value_offset = t.offset;
    in_s.value_length = t.length;
    in_s.stamp        = t.stamp;
    in_s.source_index = t.source;
    do @(posedge clk); while (in_s.ready !== 1'b1);
    merge_sb.note(act, t);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic hold_until_drained();
    in_s.valid = 1'b0;
    while (merge_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic directed_checks();
    // Pull on an empty store: batch finished straight away.
    push_beat(ACT_PULL, mk_tuple('0, '0, '0, '0, '0));
    // Field extremes, all ones and all zeros.
    push_beat(ACT_LOAD, mk_tuple('1, '1, '1, '1, 4'hF));
    push_beat(ACT_LOAD, mk_tuple('0, '0, '0, '0, 4'h0));
    // Key 5: full tie between the first two (first loaded wins), a higher
    // source and an older stamp that both lose.
    push_beat(ACT_LOAD, mk_tuple(64'd5, 64'hA, 32'd1, 64'd7, 4'd3));
    push_beat(ACT_LOAD, mk_tuple(64'd5, 64'hB, 32'd2, 64'd7, 4'd3));
    push_beat(ACT_LOAD, mk_tuple(64'd5, 64'hC, 32'd3, 64'd7, 4'd9));
    push_beat(ACT_LOAD, mk_tuple(64'd5, 64'hD, 32'd4, 64'd6, 4'd0));
    // Key 9: equal stamps settle on the lower source; the older stamp loses.
    push_beat(ACT_LOAD, mk_tuple(64'd9, 64'h10, 32'd5, 64'd4, 4'd8));
    push_beat(ACT_LOAD, mk_tuple(64'd9, 64'h11, 32'd6, 64'd4, 4'd2));
    push_beat(ACT_LOAD, mk_tuple(64'd9, 64'h12, 32'd7, 64'd3, 4'd0));
    push_beat(ACT_PULL, any_tuple());
    // Load during the drain at the last returned key: never returned.
    push_beat(ACT_LOAD, mk_tuple('0, 64'h20, 32'd8, '1, 4'd0));
    push_beat(ACT_PULL, any_tuple());
    // One load below the last key (lost) and one above it (returned).
    push_beat(ACT_LOAD, mk_tuple(64'd3, 64'h30, 32'd9, 64'd1, 4'd1));
    push_beat(ACT_LOAD, mk_tuple(64'd100, 64'h31, 32'd10, 64'd1, 4'd1));
    // 9, 100, all ones flagged last, then finished, then finished again on empty.
    repeat (5) push_beat(ACT_PULL, any_tuple());
  endtask

  // One batch: a run of loads, then pulls to the end with the odd load mixed in.
  // A full batch overfills the store so the tail loads are dropped; about one
  // small batch in ten breaks off the drain early and carries into the next.
  task automatic random_batch(bit overfill);
    int n_loads;
    int n_pulls;
    if (overfill) begin
      fill_pool(24);
      n_loads = CAPACITY + $urandom_range(1, 4);
    end else begin
      fill_pool($urandom_range(1, 8));
      n_loads = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
    end
    repeat (n_loads) push_beat(ACT_LOAD, any_tuple());
    if (!overfill && $urandom_range(9) == 0) begin
      n_pulls = $urandom_range(3);
      repeat (n_pulls) push_beat(ACT_PULL, any_tuple());
      return;
    end
    do begin
      if ($urandom_range(11) == 0) push_beat(ACT_LOAD, any_tuple());
      else                         push_beat(ACT_PULL, any_tuple());
    end while (!merge_sb.batch_ended);
    // Sometimes pull again on the now empty store.
    if ($urandom_range(4) == 0) push_beat(ACT_PULL, any_tuple());
  endtask

  task automatic run_mix(int send_pct, int take_pct, bit with_overfill);
    int stop_at;
    hold_until_drained();
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    stop_at       = items_sent + ITEMS_PER_MIX;
    if (with_overfill) random_batch(1'b1);
    while (items_sent < stop_at) random_batch(1'b0);
  endtask

  initial begin
    merge_sb          = new();
    send_idle_pct     = 20;
    take_idle_pct     = 81;
    items_sent        = 0;
    cycle_count       = 0;
    in_s.valid        = 1'b0;
    in_s.action       = ACT_LOAD;
    in_s.key          = '0;
    in_s.value_offset = '0;
    in_s.value_length = '0;
    in_s.stamp        = '0;
    in_s.source_index = '0;
    out_s.ready       = 1'b0;
    fill_pool(8);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_checks();
    run_mix(20, 81, 1'b1);
    run_mix(81, 20, 1'b0);
    run_mix(0, 0, 1'b1);

    // Stop sending, collect what is owed, then watch for strays.
    in_s.valid = 1'b0;
    while (merge_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d loads (%0d dropped on a full store), %0d merged tuples, %0d batch ends",
             merge_sb.n_loaded, merge_sb.n_dropped, merge_sb.n_tuples, merge_sb.n_finished);
    $display("idling mixes 20/81, 81/20 and none; %0d beats sent, %0d mismatches",
             items_sent, merge_sb.errors);
    if (merge_sb.errors == 0) begin
      $display("** sorted_merge_newest_wins: PASSED **");
    end else begin
      $display("** sorted_merge_newest_wins: FAILED **");
    end
    $finish;
  end

endmodule
